[rtl/gre_pkg.sv]
package gre_pkg;

  // default sizes of the grid
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 4096;

  // one chunk is 16 blocks
  localparam int BLOCK_SHIFT = 4;

  // register and field widths
  localparam int MD_W   = 7;
  localparam int GW_W   = 7;
  localparam int ORG_W  = 25;
  localparam int POS_W  = 26;
  localparam int RW_W   = 7;
  localparam int RH_W   = 13;
  localparam int AREA_W = 19;
  localparam int DIST_W = 59;

  // width of coordinate math and of one multiplier operand
  localparam int CALC_W = 32;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_MIN_DIM  = 2'd0,
    REG_GRID_W   = 2'd1,
    REG_ORIGIN_X = 2'd2,
    REG_ORIGIN_Z = 2'd3
  } reg_idx_t;

endpackage

[rtl/gre_height_store.sv]
module gre_height_store #(
  parameter int DEPTH = gre_pkg::MAX_COLS_DEF,
  parameter int DW = $clog2(gre_pkg::MAX_ROWS_DEF + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rd_q;
  logic             vld_q;

  // entries never written since a clear read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[addr];
      if (clear) begin
        vld <= '0;
      end else if (we) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_q <= mem[addr];
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule

[rtl/grid_rectangle_enumerator.sv]
// Rectangle finder over a binary grid fed one cell per word in row-major order.
// A run height is kept per column; for a set cell the block walks left from the
// current column over nonzero heights, tracking the minimum, and sends one word
// for every span whose width and height both reach min_dimension, narrowest
// first, with last set on the final one. A clear cell is taken and the block is
// ready again after S_RDC and S_UPD. A set cell keeps it busy through those, then
// S_RD and S_CHK per column walked and S_MA, S_MX, S_MZ and S_PUSH per rectangle
// found, plus any time the output register is held by stall. The walk ends at a
// zero height, at column zero, or once the running minimum falls below
// min_dimension. The cost comes from the single read port of the height memory
// and the one shared 32x32 multiplier that forms area and both squared center
// terms in turn. Heights are held in a memory with per-column valid bits, so
// reset and new_grid clear it at once with no clearing pass. Rows past MAX_ROWS
// are taken and dropped until new_grid starts a fresh grid.
module grid_rectangle_enumerator #(
  parameter int MAX_COLS = gre_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gre_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // cell input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cell_req,
  input  logic                              new_grid,
  // rectangle output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gre_pkg::POS_W-1:0]  rect_x,
  output logic signed [gre_pkg::POS_W-1:0]  rect_z,
  output logic [gre_pkg::RW_W-1:0]          rect_width,
  output logic [gre_pkg::RH_W-1:0]          rect_height,
  output logic [gre_pkg::AREA_W-1:0]        rect_area,
  output logic [gre_pkg::DIST_W-1:0]        distance_sq,
  output logic                              last,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gre_pkg::APB_AW-1:0]        paddr,
  input  logic [gre_pkg::APB_DW-1:0]        pwdata,
  output logic [gre_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import gre_pkg::*;

  localparam int IW = $clog2(MAX_COLS);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int MW = (HW > MD_W) ? HW : MD_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RDC  = 10'b0000000010,
    S_UPD  = 10'b0000000100,
    S_RD   = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_MA   = 10'b0000100000,
    S_MX   = 10'b0001000000,
    S_MZ   = 10'b0010000000,
    S_PUSH = 10'b0100000000,
    S_END  = 10'b1000000000
  } state_t;

  // configuration registers
  logic [MD_W-1:0]         md;
  logic [GW_W-1:0]         gw;
  logic [ORG_W-1:0]        ox;
  logic [ORG_W-1:0]        oz;

  // sequencer and grid position
  state_t                  state;
  state_t                  state_next;
  logic [IW-1:0]           col;
  logic [HW-1:0]           row;

  // walk registers
  logic [IW-1:0]           idx;      // left edge of the span under test
  logic [HW-1:0]           row_q;
  logic                    cell_q;
  logic [WW-1:0]           w;
  logic [HW-1:0]           minh;
  logic [CALC_W-1:0]       rx_q;
  logic [CALC_W-1:0]       rz_q;
  logic [CALC_W-1:0]       ax_q;
  logic [CALC_W-1:0]       az_q;
  logic [2*CALC_W-1:0]     prod;
  logic [2*CALC_W-1:0]     dsum;
  logic [AREA_W-1:0]       area_q;

  // one rectangle held back until we know whether it is the last
  logic                    pend_valid;
  logic [POS_W-1:0]        pend_x;
  logic [POS_W-1:0]        pend_z;
  logic [RW_W-1:0]         pend_w;
  logic [RH_W-1:0]         pend_h;
  logic [AREA_W-1:0]       pend_area;
  logic [DIST_W-1:0]       pend_dist;

  // output register
  logic [POS_W-1:0]        out_x;
  logic [POS_W-1:0]        out_z;
  logic [RW_W-1:0]         out_w;
  logic [RH_W-1:0]         out_h;
  logic [AREA_W-1:0]       out_area;
  logic [DIST_W-1:0]       out_dist;
  logic                    out_last;

  // control strobes
  logic                    in_acc;
  logic                    out_acc;
  logic                    out_free;
  logic                    cfg_we;
  logic                    store_we;
  logic                    store_clear;
  logic                    out_load;
  logic                    out_last_next;
  logic                    pend_load;
  logic                    pend_drop;
  logic                    advance;
  logic                    mul_en;

  // accept-time position math
  logic [GW_W-1:0]         cols;
  logic [IW-1:0]           col_eff;
  logic [HW-1:0]           row_eff;
  logic [IW-1:0]           c_eff;
  logic                    end_row;
  logic                    ignore;

  // walk step math
  logic [HW-1:0]           rd_h;
  logic [HW-1:0]           h_new;
  logic [HW-1:0]           minh_n;
  logic                    stop;
  logic                    qual;
  logic [CALC_W-1:0]       ox_ext;
  logic [CALC_W-1:0]       oz_ext;
  logic [CALC_W-1:0]       cx;
  logic [CALC_W-1:0]       cz;
  logic [CALC_W-1:0]       cx_mag;
  logic [CALC_W-1:0]       cz_mag;
  logic [CALC_W-1:0]       mul_a;
  logic [CALC_W-1:0]       mul_b;
  logic [2*CALC_W-1:0]     dist_sum;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;

  // ---------------------------------------------------------------------------
  // grid position: clamp the width and the column as the grid is defined
  // ---------------------------------------------------------------------------
  always_comb begin
    if (gw == '0) begin
      cols = GW_W'(1);
    end else if (gw > GW_W'(MAX_COLS)) begin
      cols = GW_W'(MAX_COLS);
    end else begin
      cols = gw;
    end
    col_eff = new_grid ? '0 : col;
    row_eff = new_grid ? '0 : row;
    c_eff   = (GW_W'(col_eff) >= cols) ? IW'(cols - GW_W'(1)) : col_eff;
    end_row = (GW_W'(c_eff) + GW_W'(1) >= cols);
    // past the last row nothing changes until a new grid
    ignore  = (32'(row_eff) >= MAX_ROWS);
  end

  // ---------------------------------------------------------------------------
  // column heights
  // ---------------------------------------------------------------------------
  assign h_new = cell_q ? (rd_h + HW'(1)) : '0;

  gre_height_store #(
    .DEPTH (MAX_COLS),
    .DW    (HW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .clear (store_clear),
    .we    (store_we),
    .addr  (idx),
    .wdata (h_new),
    .rdata (rd_h)
  );

  // ---------------------------------------------------------------------------
  // one step of the leftward walk
  // ---------------------------------------------------------------------------
  always_comb begin
    minh_n = (rd_h < minh) ? rd_h : minh;
    // the minimum only falls, so once below the limit nothing further qualifies
    stop   = (rd_h == '0) || (MW'(minh_n) < MW'(md));
    qual   = !stop && (MW'(w) >= MW'(md));
    ox_ext = {{(CALC_W - ORG_W){ox[ORG_W-1]}}, ox};
    oz_ext = {{(CALC_W - ORG_W){oz[ORG_W-1]}}, oz};
    // rectangle center in chunks and its magnitude; the shift to blocks comes in S_MA
    cx     = rx_q + CALC_W'(w >> 1);
    cz     = rz_q + CALC_W'(minh >> 1);
    cx_mag = cx[CALC_W-1] ? (CALC_W'(0) - cx) : cx;
    cz_mag = cz[CALC_W-1] ? (CALC_W'(0) - cz) : cz;
    dist_sum = dsum + prod;
  end

  // shared multiplier: area, then x squared, then z squared
  always_comb begin
    case (state)
      S_MA: begin
        mul_a = CALC_W'(w);
        mul_b = CALC_W'(minh);
      end
      S_MX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      default: begin
        mul_a = az_q;
        mul_b = az_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    store_we      = 1'b0;
    store_clear   = 1'b0;
    out_load      = 1'b0;
    out_last_next = 1'b0;
    pend_load     = 1'b0;
    pend_drop     = 1'b0;
    advance       = 1'b0;
    mul_en        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          store_clear = new_grid;
          if (!ignore) begin
            state_next = S_RDC;
          end
        end
      end
      S_RDC: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        store_we   = 1'b1;
        state_next = cell_q ? S_RD : S_IDLE;
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stop) begin
          state_next = S_END;
        end else if (qual) begin
          state_next = S_MA;
        end else if (idx == '0) begin
          state_next = S_END;
        end else begin
          advance    = 1'b1;
          state_next = S_RD;
        end
      end
      S_MA: begin
        mul_en     = 1'b1;
        state_next = S_MX;
      end
      S_MX: begin
        mul_en     = 1'b1;
        state_next = S_MZ;
      end
      S_MZ: begin
        mul_en     = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // the held rectangle is not the last, since a newer one exists
        if (!pend_valid || out_free) begin
          pend_load = 1'b1;
          out_load  = pend_valid;
          if (idx == '0) begin
            state_next = S_END;
          end else begin
            advance    = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_END: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_last_next = 1'b1;
          pend_drop     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      col        <= '0;
      row        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      md         <= MD_W'(1);
      gw         <= GW_W'(64);
      ox         <= '0;
      oz         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MIN_DIM:  md <= pwdata[MD_W-1:0];
          REG_GRID_W:   gw <= pwdata[GW_W-1:0];
          REG_ORIGIN_X: ox <= pwdata[ORG_W-1:0];
          REG_ORIGIN_Z: oz <= pwdata[ORG_W-1:0];
          default: ;
        endcase
      end
      // step the grid position as soon as a cell is taken
      if (in_acc && !ignore) begin
        if (end_row) begin
          col <= '0;
          row <= row_eff + HW'(1);
        end else begin
          col <= c_eff + IW'(1);
          row <= row_eff;
        end
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_drop) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx    <= c_eff;
      row_q  <= row_eff;
      cell_q <= cell_req;
    end
    if (state == S_UPD) begin
      minh <= '1;
      w    <= WW'(1);
    end
    if (state == S_CHK) begin
      minh <= minh_n;
      rx_q <= ox_ext + CALC_W'(idx);
      // top row of a span of height minh ending on this row
      rz_q <= oz_ext + CALC_W'(row_q) + CALC_W'(1) - CALC_W'(minh_n);
    end
    if (advance) begin
      idx <= idx - IW'(1);
      w   <= w + WW'(1);
    end
    if (state == S_MA) begin
      ax_q <= cx_mag << BLOCK_SHIFT;
      az_q <= cz_mag << BLOCK_SHIFT;
    end
    if (state == S_MX) begin
      area_q <= prod[AREA_W-1:0];
    end
    if (state == S_MZ) begin
      dsum <= prod;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (out_load) begin
      out_x    <= pend_x;
      out_z    <= pend_z;
      out_w    <= pend_w;
      out_h    <= pend_h;
      out_area <= pend_area;
      out_dist <= pend_dist;
      out_last <= out_last_next;
    end
    if (pend_load) begin
      pend_x    <= rx_q[POS_W-1:0];
      pend_z    <= rz_q[POS_W-1:0];
      pend_w    <= RW_W'(w);
      pend_h    <= RH_W'(minh);
      pend_area <= area_q;
      pend_dist <= dist_sum[DIST_W-1:0];
    end
  end

  // register readback
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MIN_DIM:  prdata = APB_DW'(md);
      REG_GRID_W:   prdata = APB_DW'(gw);
      REG_ORIGIN_X: prdata = APB_DW'(ox);
      REG_ORIGIN_Z: prdata = APB_DW'(oz);
      default:      prdata = '0;
    endcase
  end

  assign rect_x      = out_x;
  assign rect_z      = out_z;
  assign rect_width  = out_w;
  assign rect_height = out_h;
  assign rect_area   = out_area;
  assign distance_sq = out_dist;
  assign last        = out_last;

endmodule

[rtl/gre_checker.sv]
module gre_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         new_grid,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gre_pkg::POS_W-1:0]    rect_x,
  input logic [gre_pkg::POS_W-1:0]    rect_z,
  input logic [gre_pkg::RW_W-1:0]     rect_width,
  input logic [gre_pkg::DIST_W-1:0]   distance_sq,
  input logic                         last
);

  import gre_pkg::*;

  // a word held by stall keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_z)
      && $stable(distance_sq) && $stable(last))
    else $error("stalled output word changed");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a cell that starts a grid is always worked on, so the block goes busy
  a_new_grid_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && new_grid |=> in_stall)
    else $error("new grid cell taken without going busy");

  // every rectangle spans at least one and at most 64 columns
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rect_width != '0 && rect_width <= RW_W'(64))
    else $error("rectangle width out of range");

endmodule

bind grid_rectangle_enumerator gre_checker u_gre_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .new_grid    (new_grid),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rect_x      (rect_x),
  .rect_z      (rect_z),
  .rect_width  (rect_width),
  .distance_sq (distance_sq),
  .last        (last)
);

[verif/gre_checker.sv]
module gre_scoreboard
  import gre_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     cell_req,
  input  logic                     new_grid,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [POS_W-1:0]  rect_x,
  input  logic signed [POS_W-1:0]  rect_z,
  input  logic [RW_W-1:0]          rect_width,
  input  logic [RH_W-1:0]          rect_height,
  input  logic [AREA_W-1:0]        rect_area,
  input  logic [DIST_W-1:0]        distance_sq,
  input  logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output int                       rect_errors,
  output int                       rects_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CHUNK_BLOCKS = 1 << BLOCK_SHIFT;
  localparam int     COL_W        = $clog2(MAX_COLS);

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_z;
    logic [RW_W-1:0]   width;
    logic [RH_W-1:0]   height;
    logic [AREA_W-1:0] area;
    logic [DIST_W-1:0] dist_sq;
    logic              last_flag;
  } rect_t;

  rect_t expected_rects[$];

  // register copies
  logic [MD_W-1:0] min_dim;
  logic [GW_W-1:0] grid_w;
  longint          org_x;
  longint          org_z;

  // grid state
  logic [RH_W-1:0]  col_h [MAX_COLS];
  logic [COL_W-1:0] col_idx;
  logic [RH_W-1:0]  row_idx;

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      rect_errors++;
    end
  endfunction

  // one cell in, every rectangle ending at it out, narrowest first
  task automatic enumerate_rects(input logic is_set, input logic fresh);
    int     cols, c, i, w, h, row_i, found;
    longint rx, rz, cx, cz;
    logic [63:0] dsum, asum;
    rect_t  r;
    if (fresh) begin
      foreach (col_h[k]) col_h[k] = '0;
      col_idx = '0;
      row_idx = '0;
    end
    // rows past the grid limit are dropped until a fresh grid
    if (row_idx >= MAX_ROWS) return;
    cols = grid_w;
    if (cols < 1) cols = 1;
    if (cols > MAX_COLS) cols = MAX_COLS;
    c = col_idx;
    if (c >= cols) c = cols - 1;
    col_h[c] = is_set ? col_h[c] + 1'b1 : '0;
    if (is_set) begin
      h = col_h[c];
      found = 0;
      row_i = row_idx;
      for (i = c; i >= 0; i--) begin
        if (col_h[i] == 0) break;
        w = c - i + 1;
        if (col_h[i] < h) h = col_h[i];
        if (w >= min_dim && h >= min_dim) begin
          rx = org_x + i;
          rz = org_z + row_i - h + 1;
          cx = (rx + w / 2) * CHUNK_BLOCKS;
          cz = (rz + h / 2) * CHUNK_BLOCKS;
          dsum = cx * cx + cz * cz;
          asum = w * h;
          r.pos_x = rx[POS_W-1:0];
          r.pos_z = rz[POS_W-1:0];
          r.width = w[RW_W-1:0];
          r.height = h[RH_W-1:0];
          r.area = asum[AREA_W-1:0];
          r.dist_sq = dsum[DIST_W-1:0];
          r.last_flag = 1'b0;
          expected_rects = {expected_rects, r};
          found++;
        end
      end
      if (found > 0) expected_rects[expected_rects.size() - 1].last_flag = 1'b1;
    end
    if (c + 1 >= cols) begin
      col_idx = '0;
      row_idx = row_idx + 1'b1;
    end else begin
      col_idx = COL_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    rect_t want;
    if (rst) begin
      min_dim = MD_W'(1);
      grid_w = GW_W'(64);
      org_x = 0;
      org_z = 0;
      foreach (col_h[k]) col_h[k] = '0;
      col_idx = '0;
      row_idx = '0;
      expected_rects.delete();
      rect_errors = 0;
      rects_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_MIN_DIM:  min_dim = pwdata[MD_W-1:0];
          REG_GRID_W:   grid_w = pwdata[GW_W-1:0];
          REG_ORIGIN_X: org_x = $signed(pwdata[ORG_W-1:0]);
          REG_ORIGIN_Z: org_z = $signed(pwdata[ORG_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) enumerate_rects(cell_req, new_grid);
      if (out_valid && !out_stall) begin
        if (expected_rects.size() == 0) begin
          $error("rectangle word with nothing expected: x %0d z %0d w %0d h %0d",
                 rect_x, rect_z, rect_width, rect_height);
          rect_errors++;
        end else begin
          want = expected_rects.pop_front();
          check_field("rect_x", $signed(want.pos_x), rect_x);
          check_field("rect_z", $signed(want.pos_z), rect_z);
          check_field("rect_width", want.width, rect_width);
          check_field("rect_height", want.height, rect_height);
          check_field("rect_area", want.area, rect_area);
          check_field("distance_sq", want.dist_sq, distance_sq);
          check_field("last", want.last_flag, last);
        end
      end
      rects_pending <= expected_rects.size();
    end
  end

endmodule

[verif/grid_rectangle_enumerator_tb.sv]
module grid_rectangle_enumerator_tb;
  import gre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // the block may still be walking a set cell with no rectangle to show:
  // a read and a check per column over 64 columns, with margin
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_CELLS  = 80;
  localparam logic [ORG_W-1:0] ORG_MAX = ORG_W'((1 << (ORG_W - 1)) - 1);
  localparam logic [ORG_W-1:0] ORG_MIN = ORG_W'(1 << (ORG_W - 1));

  // receiver behavior, changed when the mode counter runs out
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SCATTER,
    STALL_RUNS
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // cell channel
  logic in_valid = 1'b0;
  logic in_stall;
  logic cell_req = 1'b0;
  logic new_grid = 1'b0;

  // rectangle channel
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POS_W-1:0]  rect_x;
  logic signed [POS_W-1:0]  rect_z;
  logic [RW_W-1:0]          rect_width;
  logic [RH_W-1:0]          rect_height;
  logic [AREA_W-1:0]        rect_area;
  logic [DIST_W-1:0]        distance_sq;
  logic                     last;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int rect_errors;
  int rects_pending;

  // sender burst state
  int   burst_left = 0;
  logic gaps_on = 1'b1;

  // receiver pattern state
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  grid_rectangle_enumerator DUT (.*);

  gre_scoreboard u_checker (.*);

  // receiver: picks a mode, holds it for a while, then picks again
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
      // long runs of stall and no stall
      default:       out_stall <= ($urandom_range(0, 7) == 0) ? !out_stall : out_stall;
    endcase
  end

  // one word on the cell channel; valid stays up across a burst
  task automatic send_cell(input logic is_set, input logic fresh);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    cell_req <= is_set;
    new_grid <= fresh;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // setup, access, then idle before the next transfer
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_grid(input logic [MD_W-1:0] md, input logic [GW_W-1:0] gw,
                              input logic [ORG_W-1:0] ox, input logic [ORG_W-1:0] oz);
    write_reg(REG_MIN_DIM, 32'(md));
    write_reg(REG_GRID_W, 32'(gw));
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Z, 32'(oz));
  endtask

  // hold the sender until every predicted rectangle has come out
  task automatic wait_rects_done();
    in_valid <= 1'b0;
    burst_left = 0;
    // pending count is registered, so it lags the edge
    @(posedge clk);
    while (rects_pending != 0) @(posedge clk);
  endtask

  // idle with margin so a register write never lands mid-walk
  task automatic quiesce();
    wait_rects_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int k, n, hold_at, rand_sent;
    logic [11:0] small_grid;
    logic [MD_W-1:0] md;
    logic [GW_W-1:0] gw;
    logic first_phase;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: min 1, 64 columns, origin at zero
    gaps_on = 1'b0;
    for (k = 0; k < 3; k++) send_cell(1'b1, 1'b0);
    quiesce();

    // 4 wide grid, three rows with a hole, origin at the x max and z min corner
    program_grid(7'd1, 7'd4, ORG_MAX, ORG_MIN);
    small_grid = 12'b1111_1011_1111;
    for (k = 0; k < 12; k++) send_cell(small_grid[11-k], k == 0);
    quiesce();

    // grid width zero acts as one column; min zero admits any span;
    // a fresh grid in the middle drops the built-up height
    gaps_on = 1'b1;
    program_grid(7'd0, 7'd0, ORG_MIN, ORG_MAX);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    quiesce();

    // min above anything the grid can hold: no rectangles at all
    program_grid(7'd127, 7'd3, ORG_MAX, ORG_MAX);
    for (k = 0; k < 6; k++) send_cell(1'b1, k == 0);
    quiesce();

    // widest row from a fresh grid with min 1: width above the column count
    // acts as 64, and the last cell gives 64 rectangles
    program_grid(7'd1, 7'd127, ORG_MIN, ORG_MIN);
    for (k = 0; k < 64; k++) send_cell(1'b1, k == 0);
    quiesce();

    // random grids: mostly narrow and dense so tall rectangles build up
    rand_sent = 0;
    first_phase = 1'b1;
    while (rand_sent < RANDOM_CELLS) begin
      md = ($urandom_range(0, 7) == 0) ? MD_W'($urandom_range(0, 127))
                                       : MD_W'($urandom_range(1, 3));
      gw = ($urandom_range(0, 5) == 0) ? GW_W'($urandom_range(0, 127))
                                       : GW_W'($urandom_range(1, 8));
      program_grid(md, gw, ORG_W'($urandom), ORG_W'($urandom));
      n = $urandom_range(10, 20);
      hold_at = $urandom_range(5, n - 5);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < n; k++) begin
        // sender stops mid-stream until the block has caught up
        if (k == hold_at && (first_phase || $urandom_range(0, 1) == 1)) wait_rects_done();
        send_cell($urandom_range(0, 4) != 0, k == 0 || $urandom_range(0, 40) == 0);
      end
      rand_sent += n;
      first_phase = 1'b0;
      quiesce();
    end

    if (rect_errors == 0 && rects_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
